FILE: src/ndef_srp_pkg.sv
// Shared types and constants for the NDEF short-record parser.
package ndef_srp_pkg;

  localparam int unsigned MAX_RECORD = 512;
  localparam int unsigned LEN_W      = 10;

  // record_kind codes
  localparam logic [2:0] KIND_RAW   = 3'd0;
  localparam logic [2:0] KIND_MIME  = 3'd1;
  localparam logic [2:0] KIND_TEXT  = 3'd2;
  localparam logic [2:0] KIND_URI   = 3'd3;
  localparam logic [2:0] KIND_WKRAW = 3'd4;

  // TNF values and header flag bits
  localparam logic [2:0] TNF_WELL_KNOWN = 3'd1;
  localparam logic [2:0] TNF_MIME       = 3'd2;
  localparam int unsigned HDR_SR_BIT    = 4;
  localparam int unsigned HDR_IL_BIT    = 3;

  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_U = 8'h55;

  // configuration register indexes
  localparam logic REG_MAX_OUT = 1'b0;
  localparam logic [LEN_W-1:0] MAX_OUT_RESET = 10'd512;

  typedef struct packed {
    logic [7:0]       in_byte;
    logic [LEN_W-1:0] record_length;
    logic             last_byte;
  } srp_in_t;

  typedef struct packed {
    logic             is_data;
    logic [7:0]       out_byte;
    logic [2:0]       record_kind;
    logic             parse_ok;
    logic [LEN_W-1:0] out_count;
    logic             run_end;
  } srp_out_t;

endpackage

FILE: src/ndef_short_record_parser_core.sv
// NDEF short-record parser: phase machine, result serialiser and config port.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_stall    | in_data  (srp_in_t)
//  out_    | output    | out_valid / out_stall  | out_data (srp_out_t)
//  cfg     | APB       | psel/penable/pwrite    | paddr, pwdata, prdata
//
// A byte is decoded in the cycle it is accepted and its results (0 to 3) land in
// a three-slot result register. One byte per cycle is sustained while each byte
// yields at most one result and out_stall is low; a byte yielding more than one
// result stalls the input while the single-result output port drains the slots.
// Synchronous active-low reset clears the phase state; max_out resets to 512.
// A stalled output keeps its transaction; the input stalls only once the slots
// cannot take the next byte's results.
module ndef_short_record_parser_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ndef_srp_pkg::srp_in_t     in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ndef_srp_pkg::srp_out_t    out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import ndef_srp_pkg::*;

  localparam logic [2:0] PH_HDR    = 3'd0;
  localparam logic [2:0] PH_TLEN   = 3'd1;
  localparam logic [2:0] PH_PLEN   = 3'd2;
  localparam logic [2:0] PH_TYPE   = 3'd3;
  localparam logic [2:0] PH_STATUS = 3'd4;
  localparam logic [2:0] PH_PREFIX = 3'd5;
  localparam logic [2:0] PH_COPY   = 3'd6;
  localparam logic [2:0] PH_IDLE   = 3'd7;

  localparam logic [LEN_W-1:0] POS_MAX = '1;

  function automatic logic [LEN_W-1:0] min_len(input logic [LEN_W:0] a,
                                                input logic [LEN_W-1:0] b);
    logic [LEN_W:0] bx;
    bx = {1'b0, b};
    min_len = (a < bx) ? a[LEN_W-1:0] : b;
  endfunction

  // configuration
  logic [LEN_W-1:0] max_out_r;

  // parse state
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [2:0]       phase_r, phase_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [7:0]       tlen_r, tlen_nxt;
  logic [7:0]       plen_r, plen_nxt;
  logic [7:0]       skip_r, skip_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] emitted_r, emitted_nxt;
  logic             failed_r, failed_nxt;

  // result slots, slot 0 is presented
  srp_out_t         slot_r [3];
  srp_out_t         slot_nxt [3];
  logic [1:0]       cnt_r;
  logic [1:0]       nres;

  logic in_acc, pop;

  assign pready    = 1'b1;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot_r[0];
  assign pop       = out_valid && !out_stall;
  assign in_stall  = !((cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop));
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_OUT) prdata = {{(32-LEN_W){1'b0}}, max_out_r};
  end

  always_comb begin
    logic [7:0]       b;
    logic [LEN_W-1:0] ln;
    logic [LEN_W:0]   sum3, sum1, sum2;
    logic [LEN_W-1:0] cap;
    logic [5:0]       lang;
    logic [1:0]       d_cnt;
    logic [7:0]       d0, d1;
    srp_out_t         st;
    b    = in_data.in_byte;
    ln   = in_data.record_length;
    sum3 = (LEN_W+1)'(3) + (LEN_W+1)'(tlen_r) + (LEN_W+1)'(b);
    sum1 = (LEN_W+1)'(1) + (LEN_W+1)'(tlen_r) + (LEN_W+1)'(b);
    sum2 = (LEN_W+1)'(2) + (LEN_W+1)'(plen_r);
    lang = b[5:0];
    cap  = '0;
    d_cnt = 2'd0;
    d0   = '0;
    d1   = '0;
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    tlen_nxt    = tlen_r;
    plen_nxt    = plen_r;
    skip_nxt    = skip_r;
    rem_nxt     = rem_r;
    emitted_nxt = emitted_r;
    failed_nxt  = failed_r;
    nres        = 2'd0;
    slot_nxt    = slot_r;
    st          = '0;

    if (in_acc) begin
      unique case (phase_r)
        PH_HDR: begin
          if (ln < LEN_W'(3) || ln > LEN_W'(MAX_RECORD) || !b[HDR_SR_BIT]) begin
            failed_nxt = 1'b1;
            phase_nxt  = PH_IDLE;
          end else if (b[HDR_IL_BIT] ||
                       (b[2:0] != TNF_WELL_KNOWN && b[2:0] != TNF_MIME)) begin
            kind_nxt  = KIND_RAW;
            phase_nxt = PH_COPY;
            cap       = min_len({1'b0, ln}, max_out_r);
            rem_nxt   = '0;
            if (cap != '0) begin
              d0      = b;
              d_cnt   = 2'd1;
              rem_nxt = cap - LEN_W'(1);
            end
          end else begin
            kind_nxt  = (b[2:0] == TNF_MIME) ? KIND_MIME : KIND_WKRAW;
            phase_nxt = PH_TLEN;
          end
        end
        PH_TLEN: begin
          tlen_nxt  = b;
          phase_nxt = PH_PLEN;
        end
        PH_PLEN: begin
          plen_nxt = b;
          if (sum3 > {1'b0, ln}) begin
            failed_nxt = 1'b1;
            phase_nxt  = PH_IDLE;
          end else if (kind_r == KIND_MIME) begin
            if (tlen_r == 8'd0 || sum1 > {1'b0, max_out_r}) begin
              failed_nxt = 1'b1;
              phase_nxt  = PH_IDLE;
            end else begin
              d0        = tlen_r;
              d_cnt     = 2'd1;
              rem_nxt   = LEN_W'(tlen_r) + LEN_W'(b);
              phase_nxt = PH_COPY;
            end
          end else if (tlen_r == 8'd1) begin
            phase_nxt = PH_TYPE;
          end else begin
            cap       = min_len(sum1, max_out_r);
            rem_nxt   = '0;
            phase_nxt = PH_COPY;
            if (cap != '0) begin
              d0      = tlen_r;
              d_cnt   = 2'd1;
              rem_nxt = cap - LEN_W'(1);
            end
          end
        end
        PH_TYPE: begin
          if (b == CHAR_T || b == CHAR_U) begin
            kind_nxt = (b == CHAR_T) ? KIND_TEXT : KIND_URI;
            if (plen_r == 8'd0) begin
              failed_nxt = 1'b1;
              phase_nxt  = PH_IDLE;
            end else begin
              phase_nxt = (b == CHAR_T) ? PH_STATUS : PH_PREFIX;
            end
          end else begin
            kind_nxt  = KIND_WKRAW;
            cap       = min_len(sum2, max_out_r);
            rem_nxt   = '0;
            phase_nxt = PH_COPY;
            if (cap != '0) begin
              d0      = tlen_r;
              d_cnt   = 2'd1;
              rem_nxt = cap - LEN_W'(1);
              if (cap != LEN_W'(1)) begin
                d1      = b;
                d_cnt   = 2'd2;
                rem_nxt = cap - LEN_W'(2);
              end
            end
          end
        end
        PH_STATUS: begin
          if ((9'(lang) + 9'd1) > 9'(plen_r)) begin
            failed_nxt = 1'b1;
            phase_nxt  = PH_IDLE;
          end else begin
            skip_nxt  = 8'(lang);
            rem_nxt   = min_len((LEN_W+1)'(plen_r - 8'd1 - 8'(lang)), max_out_r);
            phase_nxt = PH_COPY;
          end
        end
        PH_PREFIX: begin
          if (b != 8'd0) begin
            failed_nxt = 1'b1;
            phase_nxt  = PH_IDLE;
          end else begin
            rem_nxt   = min_len((LEN_W+1)'(plen_r - 8'd1), max_out_r);
            phase_nxt = PH_COPY;
          end
        end
        PH_COPY: begin
          if (skip_r != 8'd0) begin
            skip_nxt = skip_r - 8'd1;
          end else if (rem_r != '0) begin
            d0      = b;
            d_cnt   = 2'd1;
            rem_nxt = rem_r - LEN_W'(1);
          end
        end
        PH_IDLE: ;
        default: ;
      endcase

      emitted_nxt = emitted_r + LEN_W'(d_cnt);
      if (pos_r != POS_MAX) pos_nxt = pos_r + LEN_W'(1);

      slot_nxt[0] = '{is_data: 1'b1, out_byte: d0, record_kind: kind_nxt,
                      parse_ok: 1'b0, out_count: '0, run_end: 1'b0};
      slot_nxt[1] = '{is_data: 1'b1, out_byte: d1, record_kind: kind_nxt,
                      parse_ok: 1'b0, out_count: '0, run_end: 1'b0};
      slot_nxt[2] = '0;
      nres        = d_cnt;

      if (in_data.last_byte) begin
        st.is_data     = 1'b0;
        st.out_byte    = '0;
        st.record_kind = kind_nxt;
        st.parse_ok    = !failed_nxt && (pos_nxt >= ln);
        st.out_count   = emitted_nxt;
        st.run_end     = 1'b1;
        slot_nxt[d_cnt] = st;
        nres        = d_cnt + 2'd1;
        // next record starts from scratch
        pos_nxt     = '0;
        phase_nxt   = PH_HDR;
        kind_nxt    = KIND_RAW;
        tlen_nxt    = '0;
        plen_nxt    = '0;
        skip_nxt    = '0;
        rem_nxt     = '0;
        emitted_nxt = '0;
        failed_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_out_r <= MAX_OUT_RESET;
      pos_r     <= '0;
      phase_r   <= PH_HDR;
      kind_r    <= KIND_RAW;
      tlen_r    <= '0;
      plen_r    <= '0;
      skip_r    <= '0;
      rem_r     <= '0;
      emitted_r <= '0;
      failed_r  <= 1'b0;
      cnt_r     <= 2'd0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_MAX_OUT) begin
        max_out_r <= pwdata[LEN_W-1:0];
      end
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      tlen_r    <= tlen_nxt;
      plen_r    <= plen_nxt;
      skip_r    <= skip_nxt;
      rem_r     <= rem_nxt;
      emitted_r <= emitted_nxt;
      failed_r  <= failed_nxt;
      if (in_acc) begin
        cnt_r <= nres;
      end else if (pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // result slots carry payload only
  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r <= slot_nxt;
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

endmodule
